// ===== rtl/core/ddm_pkg.sv =====
// Shared types, sizes and codes of the decimal digit multiplier.
// No dependencies; every other file in rtl/core imports this package.
package ddm_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int DIGIT_W     = 4;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // Pair count 0..MAX_DIGITS, operand index, product index and 0..2n positions
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PROD_DIGITS = 2 * MAX_DIGITS;
    localparam int PIDX_W      = $clog2(PROD_DIGITS);
    localparam int POS_W       = PIDX_W + 1;

    // Column sum plus carry stays below 90 per digit of the operands
    localparam int ACC_W       = $clog2(90 * MAX_DIGITS + 1);

    // floor(s / 10) = (s * RECIP) >> RECIP_SH, exact for s below 16384
    localparam int RECIP_SH    = 16;
    localparam int RECIP       = 6554;

    // Queue between front and back
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QLVL_W      = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_a;
        logic [DIGIT_W-1:0] digit_b;
        logic               last_digit;
    } in_beat_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] product_digit;
        logic               last_out;
        logic               input_error;
    } out_beat_t;

    // One classified pair: digits already cleaned, keep = room to store it
    typedef struct packed {
        logic [DIGIT_W-1:0] digit_a;
        logic [DIGIT_W-1:0] digit_b;
        logic               last;
        logic               keep;
        logic               err;
    } q_entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QLVL_W-1:0] level;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_COL  = 4'b0100,
        ST_EMIT = 4'b1000
    } back_state_t;

endpackage

// ===== rtl/core/decimal_digit_multiplier_core.sv =====
// Top level of the decimal digit multiplier: front, pair queue and back.
// Depends on ddm_pkg, ddm_front, ddm_queue and ddm_back.
//
//   channel | ports                      | beat
//   --------+----------------------------+---------------------------------------
//   input   | s_valid, s_ready, s_data   | digit_a, digit_b, last_digit
//   result  | m_valid, m_ready, m_data   | product_digit, last_out, input_error
//
// Pairs are taken one per cycle while the 4-entry queue has room.
// A run of n pairs is multiplied one term at a time in the back end's single 4x4
// multiplier, a column step per product digit, then emits 2n digits, one per beat.
// Reset is synchronous and clears control state only; no clearing pass is needed.
// A stalled result holds in the output register; the front keeps filling the queue.
module decimal_digit_multiplier_core import ddm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    q_stat_t  q_stat;
    q_entry_t q_entry;
    q_entry_t q_head;
    logic     q_push;
    logic     q_pop;

    ddm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    ddm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    ddm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTH
    a_digit_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.product_digit <= DIGIT_MAX))
        else $error("product digit above nine");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/ddm_front.sv =====
// Front end: accepts digit pair beats, cleans and classifies them, pushes to the queue.
// Depends on ddm_pkg.
module ddm_front import ddm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    input  q_stat_t  q_stat,
    output logic     q_push,
    output q_entry_t q_entry
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             bad_a, bad_b, run_full;

    assign s_ready  = !q_stat.full;
    assign q_push   = s_valid && s_ready;

    assign bad_a    = s_data.digit_a > DIGIT_MAX;
    assign bad_b    = s_data.digit_b > DIGIT_MAX;
    assign run_full = cnt_reg == CNT_W'(MAX_DIGITS);

    always_comb begin
        q_entry.digit_a = bad_a ? '0 : s_data.digit_a;
        q_entry.digit_b = bad_b ? '0 : s_data.digit_b;
        q_entry.last    = s_data.last_digit;
        q_entry.keep    = !run_full;
        q_entry.err     = bad_a || bad_b || run_full;
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (q_push) begin
            if (s_data.last_digit) begin
                cnt_next = '0;
            end else if (!run_full) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/ddm_queue.sv =====
// Short FIFO of classified pairs between front and back.
// Depends on ddm_pkg.
module ddm_queue import ddm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output q_stat_t  stat
);

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] level_reg, level_next;
    logic              do_push, do_pop;

    assign stat.full  = level_reg == QLVL_W'(QDEPTH);
    assign stat.empty = level_reg == '0;
    assign stat.level = level_reg;
    assign head       = mem_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop) begin
            level_next = level_reg + QLVL_W'(1);
        end else if (do_pop && !do_push) begin
            level_next = level_reg - QLVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== rtl/core/ddm_back.sv =====
// Back end: stores operand digits, runs the column-wise multiply-accumulate,
// and drives the product digit beats through an output register. Depends on ddm_pkg.
module ddm_back import ddm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_entry_t  q_head,
    input  q_stat_t   q_stat,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic [DIGIT_W-1:0] a_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] b_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] prod_mem [PROD_DIGITS];

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             err_reg, err_next;
    logic [POS_W-1:0] k_reg, k_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [POS_W-1:0] ptr_reg, ptr_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] carry_reg, carry_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;

    logic                    store_en, prod_we, emit_last, out_free;
    logic [POS_W-1:0]        n_ext, total, k_inc, hi_k, lo_k1, hi_k1, a_pos, b_pos, w_pos;
    logic [2*DIGIT_W-1:0]    mac_prod;
    logic [ACC_W-1:0]        col_sum, quo, rem;
    logic [ACC_W+RECIP_SH-1:0] scaled;

    // Lowest and highest less-significant index p of column k with p + q = k
    function automatic logic [POS_W-1:0] col_lo(logic [POS_W-1:0] k, logic [POS_W-1:0] n);
        col_lo = (k >= n) ? k - n + POS_W'(1) : '0;
    endfunction

    function automatic logic [POS_W-1:0] col_hi(logic [POS_W-1:0] k, logic [POS_W-1:0] n);
        col_hi = (k < n) ? k : n - POS_W'(1);
    endfunction

    assign n_ext = POS_W'(n_reg);
    assign total = n_ext << 1;
    assign k_inc = k_reg + POS_W'(1);
    assign hi_k  = col_hi(k_reg, n_ext);
    assign lo_k1 = col_lo(k_inc, n_ext);
    assign hi_k1 = col_hi(k_inc, n_ext);

    // Operand stores hold most significant digit first
    assign a_pos    = n_ext - POS_W'(1) - p_reg;
    assign b_pos    = n_ext - POS_W'(1) - (k_reg - p_reg);
    assign mac_prod = a_mem[a_pos[IDX_W-1:0]] * b_mem[b_pos[IDX_W-1:0]];

    // Column digit and carry: divide by ten through the reciprocal
    assign col_sum = acc_reg + carry_reg;
    assign scaled  = (ACC_W+RECIP_SH)'(col_sum) * (ACC_W+RECIP_SH)'(RECIP);
    assign quo     = scaled[ACC_W+RECIP_SH-1:RECIP_SH];
    assign rem     = col_sum - ((quo << 3) + (quo << 1));
    assign w_pos   = total - POS_W'(1) - k_reg;

    assign store_en  = (state_reg == ST_LOAD) && !q_stat.empty && q_head.keep
                       && (cnt_reg < CNT_W'(MAX_DIGITS));
    assign prod_we   = state_reg == ST_COL;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_last = ptr_reg == total - POS_W'(1);

    assign q_pop   = (state_reg == ST_LOAD) && !q_stat.empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        err_next     = err_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        ptr_next     = ptr_reg;
        acc_next     = acc_reg;
        carry_next   = carry_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_LOAD: begin
                if (q_pop) begin
                    if (store_en) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    err_next = err_reg || q_head.err;
                    if (q_head.last) begin
                        n_next     = cnt_next;
                        k_next     = '0;
                        p_next     = '0;
                        acc_next   = '0;
                        carry_next = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                acc_next = acc_reg + ACC_W'(mac_prod);
                if (p_reg == hi_k) begin
                    state_next = ST_COL;
                end else begin
                    p_next = p_reg + POS_W'(1);
                end
            end
            ST_COL: begin
                carry_next = quo;
                acc_next   = '0;
                if (k_reg == total - POS_W'(1)) begin
                    ptr_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    k_next = k_inc;
                    p_next = lo_k1;
                    // top column has no terms: go straight to its digit
                    state_next = (lo_k1 > hi_k1) ? ST_COL : ST_MAC;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.product_digit = prod_mem[ptr_reg[PIDX_W-1:0]];
                    m_data_next.last_out      = emit_last;
                    m_data_next.input_error   = err_reg;
                    ptr_next                  = ptr_reg + POS_W'(1);
                    if (emit_last) begin
                        cnt_next   = '0;
                        err_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            a_mem[cnt_reg[IDX_W-1:0]] <= q_head.digit_a;
            b_mem[cnt_reg[IDX_W-1:0]] <= q_head.digit_b;
        end
        if (prod_we) begin
            prod_mem[w_pos[PIDX_W-1:0]] <= rem[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        ptr_reg    <= ptr_next;
        acc_reg    <= acc_next;
        carry_reg  <= carry_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== bench/tb_decimal_digit_multiplier_core.sv =====
// Self-checking bench for decimal_digit_multiplier_core: digit pairs in, product digits out.
// Depends on ddm_pkg and the core; carries its own digit-column product predictor.
module tb_decimal_digit_multiplier_core;
    import ddm_pkg::*;

    typedef struct {
        in_beat_t beat;
        bit       hold;   // wait until every product digit has come before sending
    } pair_send_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    pair_send_t pairs_to_send[$];
    out_beat_t  digits_due[$];
    int         queued_pairs   = 0;
    int         mismatch_count = 0;
    int         digits_seen    = 0;
    int         send_gap       = 0;
    int         send_calm      = 0;
    int         recv_stall     = 0;
    int         recv_calm      = 0;
    logic       drained        = 1'b1;

    // Operand digits of the run being loaded
    logic [DIGIT_W-1:0] held_a[MAX_DIGITS];
    logic [DIGIT_W-1:0] held_b[MAX_DIGITS];
    int unsigned        pairs_held = 0;
    bit                 run_bad    = 1'b0;

    decimal_digit_multiplier_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 100) begin
            $display("mismatch at digit %0d: %s", digits_seen, msg);
        end
        mismatch_count++;
    endtask

    // Mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Take one accepted pair; on the last mark, queue all 2n product digits
    task automatic load_pair(input in_beat_t b);
        logic [DIGIT_W-1:0] da;
        logic [DIGIT_W-1:0] db;
        int unsigned        col[PROD_DIGITS];
        logic [3:0]         prod[PROD_DIGITS];
        int unsigned        n;
        int unsigned        carry;
        int unsigned        sum;
        out_beat_t          o;
        da = b.digit_a;
        db = b.digit_b;
        if (da > DIGIT_MAX) begin
            run_bad = 1'b1;
            da = '0;
        end
        if (db > DIGIT_MAX) begin
            run_bad = 1'b1;
            db = '0;
        end
        if (pairs_held < MAX_DIGITS) begin
            held_a[pairs_held] = da;
            held_b[pairs_held] = db;
            pairs_held++;
        end else begin
            run_bad = 1'b1;  // drop the pair past capacity
        end
        if (!b.last_digit) return;

        n = pairs_held;
        for (int k = 0; k < PROD_DIGITS; k++) col[k] = 0;
        // col[k] has weight 10^k; operand index 0 is the most significant digit
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                col[(n - 1 - i) + (n - 1 - j)] += held_a[i] * held_b[j];
            end
        end
        carry = 0;
        for (int k = 0; k < 2 * n; k++) begin
            sum = col[k] + carry;
            prod[2 * n - 1 - k] = 4'(sum % 10);
            carry = sum / 10;
        end
        for (int k = 0; k < 2 * n; k++) begin
            o.product_digit = prod[k];
            o.last_out      = (k == 2 * n - 1);
            o.input_error   = run_bad;
            digits_due.push_back(o);
        end
        pairs_held = 0;
        run_bad    = 1'b0;
    endtask

    task automatic add_pair(input logic [3:0] a, input logic [3:0] b, input bit is_last,
                            input bit hold);
        pair_send_t p;
        p.beat.digit_a    = a;
        p.beat.digit_b    = b;
        p.beat.last_digit = is_last;
        p.hold            = hold;
        pairs_to_send.push_back(p);
        queued_pairs++;
    endtask

    function automatic logic [3:0] random_digit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)  return 4'($urandom_range(10, 15));
        if (r < 16) return 4'd9;
        if (r < 24) return 4'd0;
        return 4'($urandom_range(0, 9));
    endfunction

    // Sender: hold the beat until accepted, then idle or present the next pair
    always @(posedge aclk) begin
        pair_send_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            s_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap--;
            s_valid <= 1'b0;
        end else if (pairs_to_send.size() == 0 ||
                     (pairs_to_send[0].hold && (s_valid || !drained))) begin
            s_valid <= 1'b0;
        end else begin
            nxt = pairs_to_send.pop_front();
            s_data   <= nxt.beat;
            s_valid  <= 1'b1;
            send_gap = pick_gap(send_calm);
        end
    end

    // Receiver: ready with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            recv_stall = pick_gap(recv_calm);
        end
    end

    // Check each product digit, then predict from the pair taken at this edge
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            drained <= 1'b1;
        end else begin
            if (m_valid && m_ready) begin
                if (digits_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat, digit %0d", m_data.product_digit));
                end else begin
                    want = digits_due.pop_front();
                    if (m_data.product_digit !== want.product_digit)
                        flag_mismatch($sformatf("product_digit %0d, want %0d",
                                                m_data.product_digit, want.product_digit));
                    if (m_data.last_out !== want.last_out)
                        flag_mismatch($sformatf("last_out %0b, want %0b",
                                                m_data.last_out, want.last_out));
                    if (m_data.input_error !== want.input_error)
                        flag_mismatch($sformatf("input_error %0b, want %0b",
                                                m_data.input_error, want.input_error));
                end
                digits_seen++;
            end
            if (s_valid && s_ready) load_pair(s_data);
            drained <= (digits_due.size() == 0);
        end
    end

    initial begin
        int run_len;
        int run_idx;
        int r;

        // Extremes, bad digits, a bad digit mid-run, and a full-width run
        add_pair(4'd9, 4'd9, 1'b1, 1'b0);
        add_pair(4'd0, 4'd0, 1'b1, 1'b0);
        add_pair(4'd15, 4'd10, 1'b1, 1'b0);
        add_pair(4'd1, 4'd2, 1'b0, 1'b0);
        add_pair(4'd11, 4'd3, 1'b0, 1'b0);
        add_pair(4'd4, 4'd5, 1'b1, 1'b0);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            add_pair(4'd9, 4'd9, i == MAX_DIGITS - 1, i == 0);
        end

        // Random runs: mostly short, some long, a few past capacity
        run_idx = 0;
        while (queued_pairs < 425) begin
            r = $urandom_range(0, 99);
            if (r < 55)      run_len = $urandom_range(1, 4);
            else if (r < 85) run_len = $urandom_range(5, 12);
            else if (r < 95) run_len = $urandom_range(13, MAX_DIGITS);
            else             run_len = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
            for (int i = 0; i < run_len; i++) begin
                add_pair(random_digit(), random_digit(), i == run_len - 1,
                         i == 0 && run_idx % 40 == 5);
            end
            run_idx++;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pairs_to_send.size() != 0 || s_valid) @(negedge aclk);
        while (digits_due.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (digits_due.size() != 0) flag_mismatch("product digits left over");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("tb: failure");
        $finish;
    end

endmodule
